// ===== hdl/lrukv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
`default_nettype none

package lrukv_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/lrukv_ctrl.sv =====
// Transaction sequencer for the LRU key-value cache.
`default_nettype none

module lrukv_ctrl
    import lrukv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output dp_cmd_t      dp_cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        in_ready          = (state_reg == S_IDLE);
        dp_cmd.capture    = in_valid && (state_reg == S_IDLE);
        dp_cmd.commit     = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
        out_valid         = out_valid_reg;

        out_valid_next = out_valid_reg;
        if (dp_cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (dp_cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (dp_cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lrukv_datapath.sv =====
// Entry store, key match, recency ranks and result register of the cache.
`default_nettype none

module lrukv_datapath
    import lrukv_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           dp_cmd,
    input  wire logic              cfg_write_enable,
    input  wire logic [CAP_W-1:0]  cfg_write_data,
    input  wire logic              command,
    input  wire logic [DATA_W-1:0] key,
    input  wire logic [DATA_W-1:0] write_value,
    output logic                   hit,
    output logic [DATA_W-1:0]      read_value,
    output logic                   evicted,
    output logic [DATA_W-1:0]      evicted_key
);

    localparam int N    = MAX_ENTRIES;
    localparam int RW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;

    logic [DATA_W-1:0] key_store_reg   [N];
    logic [DATA_W-1:0] value_store_reg [N];
    logic [N-1:0]      valid_reg;
    logic [N-1:0]      valid_next;
    logic [RW-1:0]     rank_reg  [N];
    logic [RW-1:0]     rank_next [N];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CAP_W-1:0]  capacity_reg;

    command_t          op_reg;
    logic [DATA_W-1:0] key_q_reg;
    logic [DATA_W-1:0] wval_q_reg;
    logic              hit_q_reg;
    logic [N-1:0]      slot_oh_reg;
    logic [RW-1:0]     slot_rank_reg;
    logic [N-1:0]      free_oh_reg;

    logic              hit_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic              evicted_reg;
    logic [DATA_W-1:0] evicted_key_reg;

    logic [N-1:0]      match;
    logic [N-1:0]      match_oh;
    logic [N-1:0]      free_oh;
    logic [RW-1:0]     match_rank;

    logic [CAPW-1:0]   cap_ext;
    logic [CAPW-1:0]   eff_cap;
    logic [CAPW-1:0]   count_ext;
    logic [CW-1:0]     count_m1;
    logic [RW-1:0]     last_rank;
    logic [RW-1:0]     victim_rank;
    logic [N-1:0]      victim_oh;
    logic              over_cap;
    logic              at_cap;
    logic [N-1:0]      key_we;
    logic [N-1:0]      value_we;
    logic [DATA_W-1:0] slot_value;
    logic [DATA_W-1:0] victim_key;
    logic              ev;
    logic [DATA_W-1:0] rval;

    // Lookup on the incoming key
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            match[i] = valid_reg[i] && (key_store_reg[i] == key);
        end
        match_oh = match & (~match + N'(1));
        free_oh  = ~valid_reg & (valid_reg + N'(1));
        match_rank = '0;
        for (int i = 0; i < N; i++)
        begin
            if (match_oh[i])
            begin
                match_rank = match_rank | rank_reg[i];
            end
        end
    end

    // Update of the captured transaction
    always_comb
    begin
        cap_ext   = CAPW'(capacity_reg);
        count_ext = CAPW'(count_reg);
        if (cap_ext == '0)
        begin
            eff_cap = CAPW'(1);
        end
        else if (cap_ext > CAPW'(N))
        begin
            eff_cap = CAPW'(N);
        end
        else
        begin
            eff_cap = cap_ext;
        end
        over_cap = count_ext > eff_cap;
        at_cap   = (count_ext >= eff_cap) || (count_reg >= CW'(N));

        count_m1  = count_reg - CW'(1);
        last_rank = count_m1[RW-1:0];
        if (op_reg == CMD_PUT && hit_q_reg && slot_rank_reg == last_rank)
        begin
            victim_rank = last_rank - RW'(1);
        end
        else
        begin
            victim_rank = last_rank;
        end
        for (int i = 0; i < N; i++)
        begin
            victim_oh[i] = valid_reg[i] && !slot_oh_reg[i] && (rank_reg[i] == victim_rank);
        end

        slot_value = '0;
        victim_key = '0;
        for (int i = 0; i < N; i++)
        begin
            if (slot_oh_reg[i])
            begin
                slot_value = slot_value | value_store_reg[i];
            end
            if (victim_oh[i])
            begin
                victim_key = victim_key | key_store_reg[i];
            end
        end

        valid_next = valid_reg;
        count_next = count_reg;
        key_we     = '0;
        value_we   = '0;
        ev         = 1'b0;
        rval       = '0;
        for (int i = 0; i < N; i++)
        begin
            rank_next[i] = rank_reg[i];
        end

        if (hit_q_reg)
        begin
            // touch the matching entry
            for (int i = 0; i < N; i++)
            begin
                if (slot_oh_reg[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && rank_reg[i] < slot_rank_reg)
                begin
                    rank_next[i] = rank_reg[i] + RW'(1);
                end
            end
            if (op_reg == CMD_GET)
            begin
                rval = slot_value;
            end
            else
            begin
                value_we = slot_oh_reg;
                if (over_cap && victim_oh != '0)
                begin
                    ev         = 1'b1;
                    count_next = count_reg - CW'(1);
                    for (int i = 0; i < N; i++)
                    begin
                        if (victim_oh[i])
                        begin
                            valid_next[i] = 1'b0;
                            rank_next[i]  = '0;
                        end
                    end
                end
            end
        end
        else if (op_reg == CMD_PUT)
        begin
            if (at_cap)
            begin
                if (victim_oh != '0)
                begin
                    ev       = 1'b1;
                    key_we   = victim_oh;
                    value_we = victim_oh;
                    for (int i = 0; i < N; i++)
                    begin
                        if (victim_oh[i])
                        begin
                            rank_next[i] = '0;
                        end
                        else if (valid_reg[i])
                        begin
                            rank_next[i] = rank_reg[i] + RW'(1);
                        end
                    end
                end
            end
            else if (free_oh_reg != '0)
            begin
                key_we     = free_oh_reg;
                value_we   = free_oh_reg;
                count_next = count_reg + CW'(1);
                for (int i = 0; i < N; i++)
                begin
                    if (free_oh_reg[i])
                    begin
                        valid_next[i] = 1'b1;
                        rank_next[i]  = '0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + RW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            count_reg    <= '0;
            capacity_reg <= CAP_RESET;
            for (int i = 0; i < N; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write_enable)
            begin
                capacity_reg <= cfg_write_data;
            end
            if (dp_cmd.commit)
            begin
                valid_reg <= valid_next;
                count_reg <= count_next;
                for (int i = 0; i < N; i++)
                begin
                    rank_reg[i] <= rank_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            op_reg        <= command_t'(command);
            key_q_reg     <= key;
            wval_q_reg    <= write_value;
            hit_q_reg     <= |match;
            slot_oh_reg   <= match_oh;
            slot_rank_reg <= match_rank;
            free_oh_reg   <= free_oh;
        end
        if (dp_cmd.commit)
        begin
            hit_reg         <= hit_q_reg;
            read_value_reg  <= rval;
            evicted_reg     <= ev;
            evicted_key_reg <= ev ? victim_key : '0;
            for (int i = 0; i < N; i++)
            begin
                if (key_we[i])
                begin
                    key_store_reg[i] <= key_q_reg;
                end
                if (value_we[i])
                begin
                    value_store_reg[i] <= wval_q_reg;
                end
            end
        end
    end

    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

endmodule

`default_nettype wire

// ===== hdl/lru_key_value_cache_top.sv =====
// Top level of the fully associative LRU key-value cache.
// The result is registered: the match is captured when the input transaction is accepted, then the update
// is committed once the output register is free; no new transaction is taken until that commit.
// A finished result waits in the output register while the next transaction is taken.
// Reset (rst_n, async, active low): all entries invalid, ranks and count zero,
// capacity 16; key and value stores are not cleared.
`default_nettype none

module lru_key_value_cache_top
    import lrukv_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_enable,
    input  wire logic [CAP_W-1:0]  cfg_write_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              command,
    input  wire logic [DATA_W-1:0] key,
    input  wire logic [DATA_W-1:0] write_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   hit,
    output logic [DATA_W-1:0]      read_value,
    output logic                   evicted,
    output logic [DATA_W-1:0]      evicted_key
);

    dp_cmd_t dp_cmd;

    lrukv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd)
    );

    lrukv_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .dp_cmd           (dp_cmd),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .command          (command),
        .key              (key),
        .write_value      (write_value),
        .hit              (hit),
        .read_value       (read_value),
        .evicted          (evicted),
        .evicted_key      (evicted_key)
    );

endmodule

`default_nettype wire
